// File: hdl/gwm_pkg.sv
`default_nettype none
package gwm_pkg;

    localparam int MaxMaskLen = 16;
    localparam int QueueDepth = 2;

    localparam logic [7:0] StarChar   = 8'h2A;
    localparam logic [7:0] AnyChar    = 8'h3F;
    localparam logic [7:0] UpperA     = 8'h41;
    localparam logic [7:0] UpperZ     = 8'h5A;
    localparam logic [7:0] CaseOffset = 8'h20;

    localparam int CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] CfgMaskLow    = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgMaskHigh   = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgMaskLength = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgCaseInsens = 3'd3;

    typedef struct packed {
        logic [7:0] char_code;
        logic       has_char;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [MaxMaskLen-1:0][7:0] chars;
        logic [MaxMaskLen-1:0]      star;
        logic [MaxMaskLen-1:0]      any;
        logic [MaxMaskLen-1:0]      in_use;
        logic                       case_insensitive;
        logic                       restart;
    } mask_info_t;

    function automatic logic [7:0] fold_char(input logic [7:0] c, input logic ci);
        if (ci && c >= UpperA && c <= UpperZ)
        begin
            return c + CaseOffset;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// File: hdl/gwm_ifs.sv
`default_nettype none
interface gwm_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       has_char;
    logic       last;

    modport source (output valid, output char_code, output has_char, output last, input ready);
    modport sink (input valid, input char_code, input has_char, input last, output ready);
endinterface

interface gwm_result_if;
    logic valid;
    logic ready;
    logic matched;

    modport source (output valid, output matched, input ready);
    modport sink (input valid, input matched, output ready);
endinterface
`default_nettype wire

// File: hdl/glob_wildcard_matcher_core.sv
// throughput: one character per cycle unless the queue is full; the back end
// updates every mask position in parallel, and a 2-entry queue absorbs a
// stalled result output; a last item passes the queue, then the output register
// reset: empty mask, exact compare, only position 0 active, queue and output empty
`default_nettype none
module glob_wildcard_matcher_core #(
    parameter int MASK_LEN = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    gwm_char_if.sink                         char_in,
    gwm_result_if.source                     result,
    input  wire logic                        cfg_we,
    input  wire logic [gwm_pkg::CfgIdxW-1:0] cfg_index,
    input  wire logic [63:0]                 cfg_data
);

    gwm_pkg::mask_info_t                info;
    logic [$clog2(MASK_LEN+1)-1:0]      used_len;
    logic                               q_full;
    logic                               push;
    gwm_pkg::item_t                     push_item;
    logic                               pop;
    logic                               head_valid;
    gwm_pkg::item_t                     head;

    gwm_cfg #(
        .MASK_LEN (MASK_LEN)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .info      (info),
        .used_len  (used_len)
    );

    gwm_front u_front (
        .char_in   (char_in),
        .q_full    (q_full),
        .info      (info),
        .push      (push),
        .push_item (push_item)
    );

    gwm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    gwm_back #(
        .MASK_LEN (MASK_LEN)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .info       (info),
        .used_len   (used_len),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .result     (result)
    );

endmodule
`default_nettype wire

// File: hdl/gwm_cfg.sv
`default_nettype none
module gwm_cfg #(
    parameter int MASK_LEN = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [gwm_pkg::CfgIdxW-1:0]      cfg_index,
    input  wire logic [63:0]                      cfg_data,
    output gwm_pkg::mask_info_t                   info,
    output logic [$clog2(MASK_LEN+1)-1:0]         used_len
);

    localparam int IdxW = $clog2(MASK_LEN + 1);

    logic [63:0] mask_low_reg;
    logic [63:0] mask_high_reg;
    logic [4:0]  mask_length_reg;
    logic        case_insens_reg;
    logic [127:0] mask_all;
    logic        known_index;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_low_reg    <= '0;
            mask_high_reg   <= '0;
            mask_length_reg <= '0;
            case_insens_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gwm_pkg::CfgMaskLow:    mask_low_reg    <= cfg_data;
                gwm_pkg::CfgMaskHigh:   mask_high_reg   <= cfg_data;
                gwm_pkg::CfgMaskLength: mask_length_reg <= cfg_data[4:0];
                gwm_pkg::CfgCaseInsens: case_insens_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            gwm_pkg::CfgMaskLow,
            gwm_pkg::CfgMaskHigh,
            gwm_pkg::CfgMaskLength,
            gwm_pkg::CfgCaseInsens: known_index = 1'b1;
            default:                known_index = 1'b0;
        endcase
    end

    assign mask_all = {mask_high_reg, mask_low_reg};

    // length above the parameter clamps to it
    assign used_len = (mask_length_reg > 5'(MASK_LEN)) ? IdxW'(MASK_LEN)
                                                       : IdxW'(mask_length_reg);

    always_comb
    begin
        info = '0;
        info.case_insensitive = case_insens_reg;
        info.restart = cfg_we && known_index;
        for (int i = 0; i < gwm_pkg::MaxMaskLen; i++)
        begin
            info.chars[i]  = gwm_pkg::fold_char(mask_all[8*i +: 8], case_insens_reg);
            info.in_use[i] = (i < MASK_LEN) && (5'(i) < 5'(used_len));
            info.star[i]   = info.in_use[i] && (info.chars[i] == gwm_pkg::StarChar);
            info.any[i]    = info.in_use[i] && (info.chars[i] == gwm_pkg::AnyChar);
        end
    end

endmodule
`default_nettype wire

// File: hdl/gwm_front.sv
`default_nettype none
module gwm_front (
    gwm_char_if.sink               char_in,
    input  wire logic              q_full,
    input  wire gwm_pkg::mask_info_t info,
    output logic                   push,
    output gwm_pkg::item_t         push_item
);

    assign char_in.ready = !q_full;

    // an item with no character that does not end a string changes nothing
    assign push = char_in.valid && char_in.ready && (char_in.has_char || char_in.last);

    always_comb
    begin
        push_item.char_code = gwm_pkg::fold_char(char_in.char_code, info.case_insensitive);
        push_item.has_char  = char_in.has_char;
        push_item.last      = char_in.last;
    end

endmodule
`default_nettype wire

// File: hdl/gwm_queue.sv
`default_nettype none
module gwm_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire gwm_pkg::item_t    push_item,
    output logic                   full,
    input  wire logic              pop,
    output logic                   head_valid,
    output gwm_pkg::item_t         head
);

    localparam int PtrW = $clog2(gwm_pkg::QueueDepth);
    localparam int CntW = $clog2(gwm_pkg::QueueDepth + 1);

    gwm_pkg::item_t entries_reg [gwm_pkg::QueueDepth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign full       = (count_reg == CntW'(gwm_pkg::QueueDepth));
    assign head_valid = (count_reg != '0);
    assign head       = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

// File: hdl/gwm_back.sv
`default_nettype none
module gwm_back #(
    parameter int MASK_LEN = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire gwm_pkg::mask_info_t          info,
    input  wire logic [$clog2(MASK_LEN+1)-1:0] used_len,
    input  wire logic                         head_valid,
    input  wire gwm_pkg::item_t               head,
    output logic                              pop,
    gwm_result_if.source                      result
);

    localparam int W      = MASK_LEN + 1;
    localparam int Levels = $clog2(W);

    // raw_reg holds positions before star closure; closure uses current mask
    logic [W-1:0]        raw_reg, raw_next;
    logic                out_valid_reg, out_valid_next;
    logic                matched_reg, matched_next;
    logic [MASK_LEN-1:0] star;
    logic [W-1:0]        cur, nxt, raw_upd, fin;

    // prefix scan: a position is reached through any run of stars before it
    function automatic logic [W-1:0] closure(input logic [W-1:0] bits,
                                             input logic [MASK_LEN-1:0] stars);
        logic [W-1:0] g, p, gn, pn;
        g = bits;
        p = {stars, 1'b0};
        for (int lv = 0; lv < Levels; lv++)
        begin
            gn = g;
            pn = p;
            for (int q = 0; q < W; q++)
            begin
                if (q >= (1 << lv))
                begin
                    gn[q] = g[q] | (p[q] & g[q - (1 << lv)]);
                    pn[q] = p[q] & p[q - (1 << lv)];
                end
            end
            g = gn;
            p = pn;
        end
        return g;
    endfunction

    assign star = info.star[MASK_LEN-1:0];

    always_comb
    begin
        cur = closure(raw_reg, star);
        nxt = '0;
        for (int p = 0; p < MASK_LEN; p++)
        begin
            if (cur[p] && info.in_use[p])
            begin
                if (info.star[p])
                begin
                    nxt[p] = 1'b1;
                end
                else if (info.any[p] || info.chars[p] == head.char_code)
                begin
                    nxt[p + 1] = 1'b1;
                end
            end
        end
        raw_upd      = head.has_char ? nxt : raw_reg;
        fin          = closure(raw_upd, star);
        matched_next = fin[used_len];
    end

    assign pop = head_valid && (!head.last || !out_valid_reg || result.ready);

    always_comb
    begin
        raw_next = raw_reg;
        if (info.restart)
        begin
            raw_next = W'(1);
        end
        else if (pop)
        begin
            raw_next = head.last ? W'(1) : raw_upd;
        end

        out_valid_next = out_valid_reg;
        if (pop && head.last)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg       <= W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            raw_reg       <= raw_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.last)
        begin
            matched_reg <= matched_next;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.matched = matched_reg;

endmodule
`default_nettype wire
